FILE: rtl/rgb_to_hsv_converter_top_assert.svh
// Assertion macros for the RGB to HSV converter checker.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef RGB_TO_HSV_CONVERTER_TOP_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_TOP_ASSERT_SVH

// checked only out of reset
`define RTHC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define RTHC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/rthc_pkg.sv
// Shared types and constants for the RGB to HSV converter.
// No dependencies; the other .sv files refer to it by scoped names.
package rthc_pkg;

  localparam int unsigned CH_W          = 8;
  localparam int unsigned SAT_W         = 8;
  localparam int unsigned HUE_W         = 11;
  localparam int unsigned SNUM_W        = 2 * CH_W;
  localparam int unsigned HUE_UNITS_DEF = 256;

  // sextant base of the hue: red 0, green 2, blue 4
  typedef enum logic [1:0] {
    SEXT_RED,
    SEXT_GREEN,
    SEXT_BLUE
  } sext_e;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] saturation;
    logic [CH_W-1:0]  brightness;
    logic             hue_undefined;
  } hsv_out_t;

  // per-pixel values carried alongside the dividers
  typedef struct packed {
    logic [CH_W-1:0] mx;
    logic [CH_W-1:0] delta;
    logic            neg;
    sext_e           sext;
    logic            undef;
  } side_t;

endpackage

FILE: rtl/rgb_to_hsv_converter_top.sv
// RGB to HSV converter, top level.
// Uses rthc_pkg, rthc_front, rthc_div and rthc_back.
//
// One pixel word in (red, green, blue), one HSV word out (hue, saturation,
// brightness, hue_undefined). Both channels use valid/stall: a word moves on
// a clock edge where valid is high and stall is low.
// Hue runs 0 .. 6*HueUnits-1 (masked to 11 bits), HueUnits per 60 degrees.
// The pipeline has two front stages, one stage per quotient bit of the
// longer divider, and the output register; with the default of 256 units
// the hue divider is the longer one. Throughput is one pixel per clock
// while the output is not stalled; each divider step is one 9-bit compare
// and subtract per stage.
// A stall on the output holds the output register; upstream stages keep
// taking words until the pipeline is full, so in_stall_o rises only when
// no stage has room. Nothing is dropped or repeated.
// Reset clears all valid bits at once; the block is ready for words as
// soon as reset is released.
module rgb_to_hsv_converter_top #(
  parameter int unsigned HueUnits = rthc_pkg::HUE_UNITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rthc_pkg::pix_in_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rthc_pkg::hsv_out_t out_word_o
);

  localparam int unsigned QuoW = $clog2(HueUnits + 1);
  localparam int unsigned NumW = rthc_pkg::CH_W + QuoW;

  logic                        front_ready;
  logic                        fd_valid, fd_ready;
  rthc_pkg::side_t             fd_side;
  logic [NumW-1:0]             fd_hnum;
  logic [rthc_pkg::SNUM_W-1:0] fd_snum;

  logic                        db_valid, db_ready;
  rthc_pkg::side_t             db_side;
  logic [QuoW-1:0]             db_hquo;
  logic [rthc_pkg::CH_W-1:0]   db_hrem;
  logic [rthc_pkg::SAT_W-1:0]  db_squo;

  assign in_stall_o = !front_ready;

  rthc_front #(
    .HueUnits (HueUnits),
    .NumW     (NumW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (front_ready),
    .in_word_i   (in_word_i),
    .out_valid_o (fd_valid),
    .out_ready_i (fd_ready),
    .out_side_o  (fd_side),
    .out_hnum_o  (fd_hnum),
    .out_snum_o  (fd_snum)
  );

  rthc_div #(
    .QuoW (QuoW),
    .NumW (NumW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fd_valid),
    .in_ready_o  (fd_ready),
    .in_side_i   (fd_side),
    .in_hnum_i   (fd_hnum),
    .in_snum_i   (fd_snum),
    .out_valid_o (db_valid),
    .out_ready_i (db_ready),
    .out_side_o  (db_side),
    .out_hquo_o  (db_hquo),
    .out_hrem_o  (db_hrem),
    .out_squo_o  (db_squo)
  );

  rthc_back #(
    .HueUnits (HueUnits),
    .QuoW     (QuoW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (db_valid),
    .in_ready_o  (db_ready),
    .in_side_i   (db_side),
    .in_hquo_i   (db_hquo),
    .in_hrem_i   (db_hrem),
    .in_squo_i   (db_squo),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

FILE: rtl/rthc_front.sv
// Front stages: max/min/difference selection, then numerator scaling.
// Uses rthc_pkg.
module rthc_front #(
  parameter int unsigned HueUnits = rthc_pkg::HUE_UNITS_DEF,
  parameter int unsigned NumW     = rthc_pkg::CH_W + $clog2(HueUnits + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  rthc_pkg::pix_in_t           in_word_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output rthc_pkg::side_t             out_side_o,
  output logic [NumW-1:0]             out_hnum_o,
  output logic [rthc_pkg::SNUM_W-1:0] out_snum_o
);

  localparam int unsigned ChW   = rthc_pkg::CH_W;
  localparam int unsigned SnumW = rthc_pkg::SNUM_W;

  logic [ChW-1:0]  r, g, b, mx, mn, mag;
  logic [ChW:0]    diff, ndiff;
  rthc_pkg::sext_e sext;
  rthc_pkg::side_t side;

  logic            a_valid_q, b_valid_q;
  logic            a_ready, b_ready;
  rthc_pkg::side_t a_side_q, b_side_q;
  logic [ChW-1:0]  a_mag_q;
  logic [NumW-1:0] b_hnum_q;
  logic [SnumW-1:0] b_snum_q;

  // tie order follows the sextant tests; ties give the same hue anyway
  always_comb begin
    r = in_word_i.red;
    g = in_word_i.green;
    b = in_word_i.blue;
    if (r > g) begin
      if (g > b) begin
        mn = b; mx = r; diff = {1'b0, g} - {1'b0, b}; sext = rthc_pkg::SEXT_RED;
      end else if (r > b) begin
        mn = g; mx = r; diff = {1'b0, g} - {1'b0, b}; sext = rthc_pkg::SEXT_RED;
      end else begin
        mn = g; mx = b; diff = {1'b0, r} - {1'b0, g}; sext = rthc_pkg::SEXT_BLUE;
      end
    end else begin
      if (b > g) begin
        mn = r; mx = b; diff = {1'b0, r} - {1'b0, g}; sext = rthc_pkg::SEXT_BLUE;
      end else if (b > r) begin
        mn = r; mx = g; diff = {1'b0, b} - {1'b0, r}; sext = rthc_pkg::SEXT_GREEN;
      end else begin
        mn = b; mx = g; diff = {1'b0, b} - {1'b0, r}; sext = rthc_pkg::SEXT_GREEN;
      end
    end
    ndiff      = -diff;
    mag        = diff[ChW] ? ndiff[ChW-1:0] : diff[ChW-1:0];
    side.mx    = mx;
    side.delta = mx - mn;
    side.neg   = diff[ChW];
    side.sext  = sext;
    // max of zero implies delta of zero
    side.undef = (side.delta == '0);
  end

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= in_valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready) begin
      a_side_q <= side;
      a_mag_q  <= mag;
    end
    if (b_ready) begin
      b_side_q <= a_side_q;
      b_hnum_q <= NumW'(a_mag_q) * NumW'(HueUnits);
      // delta * 255
      b_snum_q <= {a_side_q.delta, {ChW{1'b0}}} - SnumW'(a_side_q.delta);
    end
  end

  assign out_valid_o = b_valid_q;
  assign out_side_o  = b_side_q;
  assign out_hnum_o  = b_hnum_q;
  assign out_snum_o  = b_snum_q;

endmodule

FILE: rtl/rthc_div.sv
// Pipelined restoring dividers, one quotient bit per stage, for hue and saturation.
// Uses rthc_pkg.
module rthc_div #(
  parameter int unsigned QuoW = 9,
  parameter int unsigned NumW = rthc_pkg::CH_W + QuoW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  rthc_pkg::side_t             in_side_i,
  input  logic [NumW-1:0]             in_hnum_i,
  input  logic [rthc_pkg::SNUM_W-1:0] in_snum_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output rthc_pkg::side_t             out_side_o,
  output logic [QuoW-1:0]             out_hquo_o,
  output logic [rthc_pkg::CH_W-1:0]   out_hrem_o,
  output logic [rthc_pkg::SAT_W-1:0]  out_squo_o
);

  localparam int unsigned ChW       = rthc_pkg::CH_W;
  localparam int unsigned SatW      = rthc_pkg::SAT_W;
  localparam int unsigned SnumW     = rthc_pkg::SNUM_W;
  localparam int unsigned NumStages = (QuoW > SatW) ? QuoW : SatW;

  // hq/sq start as the low numerator bits and fill with quotient bits
  typedef struct packed {
    rthc_pkg::side_t side;
    logic [ChW-1:0]  hrem;
    logic [QuoW-1:0] hq;
    logic [ChW-1:0]  srem;
    logic [SatW-1:0] sq;
  } dstage_t;

  // returns {quotient bit, new remainder}
  function automatic logic [ChW:0] div_step(input logic [ChW-1:0] rem,
                                            input logic           nbit,
                                            input logic [ChW-1:0] den);
    logic [ChW:0] trial;
    logic [ChW:0] diff;
    trial = {rem, nbit};
    diff  = trial - {1'b0, den};
    if (trial >= {1'b0, den}) begin
      return {1'b1, diff[ChW-1:0]};
    end else begin
      return {1'b0, trial[ChW-1:0]};
    end
  endfunction

  dstage_t                st_q [NumStages];
  logic [NumStages-1:0]   valid_q;
  logic [NumStages:0]     ready;
  dstage_t                entry;

  assign entry.side = in_side_i;
  assign entry.hrem = in_hnum_i[NumW-1:QuoW];
  assign entry.hq   = in_hnum_i[QuoW-1:0];
  assign entry.srem = in_snum_i[SnumW-1:SatW];
  assign entry.sq   = in_snum_i[SatW-1:0];

  assign ready[NumStages] = out_ready_i;
  assign in_ready_o       = ready[0];

  for (genvar k = 0; k < NumStages; k++) begin : g_stage
    dstage_t src;
    dstage_t nxt;
    logic    prev_valid;

    if (k == 0) begin : g_first
      assign src        = entry;
      assign prev_valid = in_valid_i;
    end else begin : g_next
      assign src        = st_q[k-1];
      assign prev_valid = valid_q[k-1];
    end

    assign nxt.side = src.side;

    if (k < QuoW) begin : g_hstep
      logic [ChW:0] hs;
      assign hs       = div_step(src.hrem, src.hq[QuoW-1], src.side.delta);
      assign nxt.hrem = hs[ChW-1:0];
      assign nxt.hq   = {src.hq[QuoW-2:0], hs[ChW]};
    end else begin : g_hpass
      assign nxt.hrem = src.hrem;
      assign nxt.hq   = src.hq;
    end

    if (k < SatW) begin : g_sstep
      logic [ChW:0] ss;
      assign ss       = div_step(src.srem, src.sq[SatW-1], src.side.mx);
      assign nxt.srem = ss[ChW-1:0];
      assign nxt.sq   = {src.sq[SatW-2:0], ss[ChW]};
    end else begin : g_spass
      assign nxt.srem = src.srem;
      assign nxt.sq   = src.sq;
    end

    assign ready[k] = !valid_q[k] || ready[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (ready[k]) begin
        valid_q[k] <= prev_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ready[k]) st_q[k] <= nxt;
    end
  end

  assign out_valid_o = valid_q[NumStages-1];
  assign out_side_o  = st_q[NumStages-1].side;
  assign out_hquo_o  = st_q[NumStages-1].hq;
  assign out_hrem_o  = st_q[NumStages-1].hrem;
  assign out_squo_o  = st_q[NumStages-1].sq;

endmodule

FILE: rtl/rthc_back.sv
// Final stage: floor correction, sextant base, wrap, and the output register.
// Uses rthc_pkg.
module rthc_back #(
  parameter int unsigned HueUnits = rthc_pkg::HUE_UNITS_DEF,
  parameter int unsigned QuoW     = $clog2(HueUnits + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  rthc_pkg::side_t            in_side_i,
  input  logic [QuoW-1:0]            in_hquo_i,
  input  logic [rthc_pkg::CH_W-1:0]  in_hrem_i,
  input  logic [rthc_pkg::SAT_W-1:0] in_squo_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output rthc_pkg::hsv_out_t         out_word_o
);

  localparam int unsigned SumW = QuoW + 4;
  localparam int unsigned HueW = rthc_pkg::HUE_W;

  logic signed [SumW-1:0] mag_up, frac, base, sum, wrapped;
  rthc_pkg::hsv_out_t     word;
  logic                   out_valid_q;
  rthc_pkg::hsv_out_t     out_word_q;

  always_comb begin
    // floor of a negative quotient rounds away from zero when inexact
    mag_up = SumW'(in_hquo_i) + SumW'(in_side_i.neg && (in_hrem_i != '0));
    frac   = in_side_i.neg ? -mag_up : mag_up;
    case (in_side_i.sext)
      rthc_pkg::SEXT_RED:   base = '0;
      rthc_pkg::SEXT_GREEN: base = SumW'(2 * HueUnits);
      rthc_pkg::SEXT_BLUE:  base = SumW'(4 * HueUnits);
      default:              base = '0;
    endcase
    sum     = base + frac;
    wrapped = sum[SumW-1] ? sum + SumW'(6 * HueUnits) : sum;

    word.hue           = in_side_i.undef ? '0 : HueW'($unsigned(wrapped));
    word.saturation    = in_side_i.undef ? '0 : in_squo_i;
    word.brightness    = in_side_i.mx;
    word.hue_undefined = in_side_i.undef;
  end

  assign in_ready_o = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) out_word_q <= word;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

FILE: rtl/rthc_checker.sv
// Port-level checker for the RGB to HSV converter, bound to the top level.
// Uses rthc_pkg and the macros in rgb_to_hsv_converter_top_assert.svh.
`include "rgb_to_hsv_converter_top_assert.svh"

module rthc_checker #(
  parameter int unsigned HueUnits = rthc_pkg::HUE_UNITS_DEF
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input rthc_pkg::hsv_out_t out_word_o
);

  localparam int unsigned HueW   = rthc_pkg::HUE_W;
  localparam int unsigned HueTop = (6 * HueUnits > 2048) ? 2047 : 6 * HueUnits - 1;

  logic stalled, undef_word, undef_clean, hue_ok;

  assign stalled     = out_valid_o && out_stall_i;
  assign undef_word  = out_valid_o && out_word_o.hue_undefined;
  assign undef_clean = (out_word_o.hue == '0) && (out_word_o.saturation == '0);
  assign hue_ok      = out_word_o.hue <= HueW'(HueTop);

  // valid is only known to be clear from the edge after reset is seen low
  `RTHC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o, "output word valid during reset")

  `RTHC_ASSERT(a_stall_holds_valid, stalled |=> out_valid_o, "stalled word dropped")

  `RTHC_ASSERT(a_stall_holds_word, stalled |=> $stable(out_word_o), "stalled word changed")

  `RTHC_ASSERT(a_undef_zero, undef_word |-> undef_clean, "undefined hue with nonzero fields")

  `RTHC_ASSERT(a_hue_range, out_valid_o |-> hue_ok, "hue beyond a full turn")

endmodule

bind rgb_to_hsv_converter_top rthc_checker #(
  .HueUnits (HueUnits)
) u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
